@@ src/ttop_pkg.sv @@
package ttop_pkg;

    localparam int PRICE_W = 32;
    localparam int FRAC_W  = 30;
    localparam int PROD_W  = 2 * PRICE_W;

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PROB       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_PROB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_PROB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISCOUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_STEPS    = 3'd6;

    localparam logic [30:0] RST_UP_PROB       = 31'd357913941;
    localparam logic [30:0] RST_MID_PROB      = 31'd357913942;
    localparam logic [30:0] RST_DOWN_PROB     = 31'd357913941;
    localparam logic [30:0] RST_STEP_DISCOUNT = 31'd1073741824;
    localparam logic [31:0] RST_UP_FACTOR     = 32'd1073741824;
    localparam logic [30:0] RST_DOWN_FACTOR   = 31'd1073741824;
    localparam logic [10:0] RST_TREE_STEPS    = 11'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LEAF_C,
        ST_UP_MUL,
        ST_UP_WR,
        ST_DN_MUL,
        ST_DN_WR,
        ST_ROW,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_M2,
        ST_M3,
        ST_DF,
        ST_WR,
        ST_FIN_RD,
        ST_FIN_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PRICE_W-1:0] value;
        logic               sat;
    } fx_t;

    // (prod + 2^29) >> 30, clamped to the price range
    function automatic fx_t fx_round(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] t;
        fx_t               r;
        t = prod + ROUND_HALF;
        if (t[PROD_W-1:PRICE_W+FRAC_W] != '0)
        begin
            r.value = '1;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = t[PRICE_W+FRAC_W-1:FRAC_W];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic fx_t sat_add(input logic [PRICE_W-1:0] a, input logic [PRICE_W-1:0] b);
        logic [PRICE_W:0] s;
        fx_t              r;
        s = {1'b0, a} + {1'b0, b};
        if (s[PRICE_W])
        begin
            r.value = '1;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = s[PRICE_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [PRICE_W-1:0] intrinsic(
        input logic [PRICE_W-1:0] price,
        input logic [PRICE_W-1:0] strike,
        input logic               call
    );
        logic [PRICE_W-1:0] r;
        r = '0;
        if (call)
        begin
            if (price > strike)
                r = price - strike;
        end
        else
        begin
            if (strike > price)
                r = strike - price;
        end
        return r;
    endfunction

endpackage

@@ src/trinomial_tree_option_pricer.sv @@
// Trinomial-tree option pricer. A request (spot, strike, call/put, European/American)
// is priced by backward induction over a tree of n = min(tree_steps, MAX_STEPS)
// levels; the result is the root value in Q16.16 plus a sticky saturation flag.
// All arithmetic goes through one 32x32 multiplier with a rounding/clamping stage,
// driven by a small sequencer: each leaf price takes a multiply step and a write
// step, and each interior node takes three weighted reads, three products, one
// discount product and one write-back. Node prices and values live in two
// single-port-write RAMs of 2*MAX_STEPS+1 words. req_stall is high for the whole
// computation; a finished result waits in the output register while the next
// request may be accepted. Configuration writes are always taken and must be
// issued only while the block is idle.
module trinomial_tree_option_pricer
    import ttop_pkg::*;
#(
    parameter int MAX_STEPS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [31:0]          spot_price,
    input  logic [31:0]          strike_price,
    input  logic                 is_call,
    input  logic                 is_american,

    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [31:0]          option_value,
    output logic                 saturated
);

    localparam int NODES = 2 * MAX_STEPS + 1;
    localparam int AW    = $clog2(NODES);
    localparam int KW    = $clog2(NODES + 1);
    localparam int SW    = $clog2(MAX_STEPS + 1);

    logic [PRICE_W-1:0] node_values [NODES];
    logic [PRICE_W-1:0] node_prices [NODES];

    state_t state_reg, state_next;

    logic [30:0] up_prob_reg, mid_prob_reg, down_prob_reg, step_discount_reg;
    logic [31:0] up_factor_reg;
    logic [30:0] down_factor_reg;
    logic [10:0] tree_steps_reg;

    logic [SW-1:0]      n_reg, n_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      pbase_reg, pbase_next;
    logic [SW-1:0]      row_reg, row_next;
    logic               sat_reg, sat_next;
    logic               call_reg, call_next;
    logic               amer_reg, amer_next;
    logic [PRICE_W-1:0] spot_reg, spot_next;
    logic [PRICE_W-1:0] strike_reg, strike_next;
    logic [PRICE_W-1:0] cur_reg, cur_next;
    logic [PRICE_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PRICE_W-1:0] vrd_reg, prd_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [31:0]        option_value_reg, option_value_next;
    logic               saturated_reg, saturated_next;

    logic [PRICE_W-1:0] mul_a, mul_b;
    logic               mem_we;
    logic [AW-1:0]      w_addr, v_raddr, p_raddr;
    logic [PRICE_W-1:0] v_wdata, p_wdata;

    logic [KW-1:0]      two_n;
    logic [AW-1:0]      last_i;
    fx_t                fx_p, sum_r;
    logic [PRICE_W-1:0] ex_val, node_val;

    assign cfg_ready    = 1'b1;
    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign option_value = option_value_reg;
    assign saturated    = saturated_reg;

    assign two_n   = KW'(n_reg) + KW'(n_reg);
    assign last_i  = AW'({row_reg - SW'(1), 1'b0});
    assign p_raddr = i_reg + pbase_reg;
    assign fx_p    = fx_round(prod_reg);
    assign ex_val  = intrinsic(prd_reg, strike_reg, call_reg);

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        i_next            = i_reg;
        pbase_next        = pbase_reg;
        row_next          = row_reg;
        sat_next          = sat_reg;
        call_next         = call_reg;
        amer_next         = amer_reg;
        spot_next         = spot_reg;
        strike_next       = strike_reg;
        cur_next          = cur_reg;
        acc_next          = acc_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;
        option_value_next = option_value_reg;
        saturated_next    = saturated_reg;
        mul_a             = cur_reg;
        mul_b             = up_factor_reg;
        mem_we            = 1'b0;
        w_addr            = i_reg;
        v_wdata           = '0;
        p_wdata           = '0;
        v_raddr           = i_reg;
        sum_r             = '0;
        node_val          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    spot_next   = spot_price;
                    strike_next = strike_price;
                    call_next   = is_call;
                    amer_next   = is_american;
                    sat_next    = 1'b0;
                    if (32'(tree_steps_reg) > 32'(MAX_STEPS))
                        n_next = SW'(MAX_STEPS);
                    else
                        n_next = SW'(tree_steps_reg);
                    state_next = ST_LEAF_C;
                end
            end
            ST_LEAF_C:
            begin
                mem_we     = 1'b1;
                w_addr     = AW'(n_reg);
                p_wdata    = spot_reg;
                v_wdata    = intrinsic(spot_reg, strike_reg, call_reg);
                cur_next   = spot_reg;
                k_next     = KW'(n_reg) + KW'(1);
                state_next = ST_UP_MUL;
            end
            ST_UP_MUL:
            begin
                mul_a = cur_reg;
                mul_b = up_factor_reg;
                if (k_reg > two_n)
                begin
                    cur_next   = spot_reg;
                    k_next     = KW'(n_reg);
                    state_next = ST_DN_MUL;
                end
                else
                    state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                mem_we     = 1'b1;
                w_addr     = AW'(k_reg);
                p_wdata    = fx_p.value;
                v_wdata    = intrinsic(fx_p.value, strike_reg, call_reg);
                sat_next   = sat_reg | fx_p.sat;
                cur_next   = fx_p.value;
                k_next     = k_reg + KW'(1);
                state_next = ST_UP_MUL;
            end
            ST_DN_MUL:
            begin
                mul_a = cur_reg;
                mul_b = {1'b0, down_factor_reg};
                if (k_reg == '0)
                begin
                    row_next   = n_reg;
                    pbase_next = AW'(1);
                    i_next     = '0;
                    state_next = ST_ROW;
                end
                else
                    state_next = ST_DN_WR;
            end
            ST_DN_WR:
            begin
                mem_we     = 1'b1;
                w_addr     = AW'(k_reg - KW'(1));
                p_wdata    = fx_p.value;
                v_wdata    = intrinsic(fx_p.value, strike_reg, call_reg);
                sat_next   = sat_reg | fx_p.sat;
                cur_next   = fx_p.value;
                k_next     = k_reg - KW'(1);
                state_next = ST_DN_MUL;
            end
            ST_ROW:
            begin
                i_next = '0;
                if (row_reg == '0)
                    state_next = ST_FIN_RD;
                else
                    state_next = ST_RD0;
            end
            ST_RD0:
            begin
                v_raddr    = i_reg + AW'(2);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                v_raddr    = i_reg + AW'(1);
                mul_a      = vrd_reg;
                mul_b      = {1'b0, up_prob_reg};
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                v_raddr    = i_reg;
                mul_a      = vrd_reg;
                mul_b      = {1'b0, mid_prob_reg};
                acc_next   = fx_p.value;
                sat_next   = sat_reg | fx_p.sat;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mul_a      = vrd_reg;
                mul_b      = {1'b0, down_prob_reg};
                sum_r      = sat_add(acc_reg, fx_p.value);
                acc_next   = sum_r.value;
                sat_next   = sat_reg | fx_p.sat | sum_r.sat;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                sum_r      = sat_add(acc_reg, fx_p.value);
                acc_next   = sum_r.value;
                sat_next   = sat_reg | fx_p.sat | sum_r.sat;
                state_next = ST_DF;
            end
            ST_DF:
            begin
                mul_a      = acc_reg;
                mul_b      = {1'b0, step_discount_reg};
                state_next = ST_WR;
            end
            ST_WR:
            begin
                node_val = fx_p.value;
                if (amer_reg && (ex_val > fx_p.value))
                    node_val = ex_val;
                mem_we   = 1'b1;
                w_addr   = i_reg;
                v_wdata  = node_val;
                p_wdata  = prd_reg;
                sat_next = sat_reg | fx_p.sat;
                if (i_reg == last_i)
                begin
                    row_next   = row_reg - SW'(1);
                    pbase_next = pbase_reg + AW'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_RD0;
                end
            end
            ST_FIN_RD:
            begin
                v_raddr    = '0;
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                acc_next   = vrd_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next    = 1'b1;
                    option_value_next = acc_reg;
                    saturated_next    = sat_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // price RAM keeps its own contents in the induction write-back
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_values[w_addr] <= v_wdata;
            if (state_reg != ST_WR)
                node_prices[w_addr] <= p_wdata;
        end
        vrd_reg <= node_values[v_raddr];
        prd_reg <= node_prices[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg         <= prod_next;
        acc_reg          <= acc_next;
        cur_reg          <= cur_next;
        spot_reg         <= spot_next;
        strike_reg       <= strike_next;
        option_value_reg <= option_value_next;
        saturated_reg    <= saturated_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            pbase_reg     <= '0;
            row_reg       <= '0;
            sat_reg       <= 1'b0;
            call_reg      <= 1'b0;
            amer_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            pbase_reg     <= pbase_next;
            row_reg       <= row_next;
            sat_reg       <= sat_next;
            call_reg      <= call_next;
            amer_reg      <= amer_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_prob_reg       <= RST_UP_PROB;
            mid_prob_reg      <= RST_MID_PROB;
            down_prob_reg     <= RST_DOWN_PROB;
            step_discount_reg <= RST_STEP_DISCOUNT;
            up_factor_reg     <= RST_UP_FACTOR;
            down_factor_reg   <= RST_DOWN_FACTOR;
            tree_steps_reg    <= RST_TREE_STEPS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_UP_PROB:       up_prob_reg       <= cfg_data[30:0];
                CFG_MID_PROB:      mid_prob_reg      <= cfg_data[30:0];
                CFG_DOWN_PROB:     down_prob_reg     <= cfg_data[30:0];
                CFG_STEP_DISCOUNT: step_discount_reg <= cfg_data[30:0];
                CFG_UP_FACTOR:     up_factor_reg     <= cfg_data;
                CFG_DOWN_FACTOR:   down_factor_reg   <= cfg_data[30:0];
                CFG_TREE_STEPS:    tree_steps_reg    <= cfg_data[10:0];
                default:           ;
            endcase
        end
    end

endmodule
